// ===== rtl/core/key_scan_voice_allocator_assert.svh =====
// Assertion macros used by the voice allocator datapath.
`ifndef KEY_SCAN_VOICE_ALLOCATOR_ASSERT_SVH
`define KEY_SCAN_VOICE_ALLOCATOR_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define KSVA_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define KSVA_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/ksva_pkg.sv =====
package ksva_pkg;

	localparam int NOTE_W      = 7;
	localparam int MAP_W       = 64;
	localparam int KEY_SPACE   = 16;
	localparam int VIDX_W      = 2;
	localparam int MAX_RESULTS = 20;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_NOTE_MAP_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_MAP_HIGH = 1'b1;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic press;
		logic rel;
		logic adv_key;
		logic flush;
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic key_last;
		logic rel_hit;
		logic hold_v;
		logic out_free;
	} dp_sts_t;

	// Note of key k: byte k of the combined map, low seven bits.
	function automatic logic [NOTE_W-1:0] key_note(input logic [MAP_W-1:0] map_lo,
			input logic [MAP_W-1:0] map_hi, input logic [3:0] k);
		logic [MAP_W-1:0] sel;
		logic [MAP_W-1:0] shifted;
		sel = k[3] ? map_hi : map_lo;
		shifted = sel >> {k[2:0], 3'b000};
		return shifted[NOTE_W-1:0];
	endfunction

endpackage

// ===== rtl/core/ksva_ctrl.sv =====
module ksva_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ksva_pkg::dp_sts_t  sts,
	output ksva_pkg::dp_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PRESS = 2'd1;
	localparam logic [1:0] S_REL   = 2'd2;
	localparam logic [1:0] S_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       go;

	// A step may emit only if the held event can move on to the output.
	assign go = !sts.hold_v || sts.out_free;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_PRESS;
				end
			end
			S_PRESS: begin
				if (go) begin
					cmd.press = 1'b1;
					cmd.adv_key = 1'b1;
					if (sts.key_last)
						state_d = S_REL;
				end
			end
			S_REL: begin
				if (go) begin
					if (sts.rel_hit) begin
						cmd.rel = 1'b1;
					end else begin
						cmd.adv_key = 1'b1;
						if (sts.key_last)
							state_d = S_FLUSH;
					end
				end
			end
			S_FLUSH: begin
				if (!sts.hold_v) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/core/ksva_datapath.sv =====
`include "key_scan_voice_allocator_assert.svh"

module ksva_datapath #(
	parameter int VOICES = 4,
	parameter int KEYS   = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [ksva_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ksva_pkg::MAP_W-1:0]         cfg_wdata,
	input  logic [ksva_pkg::KEY_SPACE-1:0]     key_word,
	input  ksva_pkg::dp_cmd_t                  cmd,
	output ksva_pkg::dp_sts_t                  sts,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic [ksva_pkg::VIDX_W-1:0]        voice_index,
	output logic [ksva_pkg::NOTE_W-1:0]        note,
	output logic                               gate,
	output logic                               last
);

	localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int KW    = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int NW    = ksva_pkg::NOTE_W;
	localparam int CNT_W = ksva_pkg::CNT_W;
	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(ksva_pkg::MAX_RESULTS);
	localparam logic [KW-1:0]    KEY_LAST = KW'(KEYS - 1);

	logic [ksva_pkg::MAP_W-1:0]     map_lo_q;
	logic [ksva_pkg::MAP_W-1:0]     map_hi_q;
	logic [ksva_pkg::KEY_SPACE-1:0] prev_q;
	logic [KEYS-1:0]                pressed_q;
	logic [KEYS-1:0]                released_q;
	logic [KW-1:0]                  key_q;
	logic [VOICES-1:0]              act_q;
	logic [NW-1:0]                  vnote_q [VOICES];
	logic [CNT_W-1:0]               cnt_q;
	logic                           hold_v_q;
	logic [VW-1:0]                  hold_voice_q;
	logic [NW-1:0]                  hold_note_q;
	logic                           hold_gate_q;
	logic                           out_valid_q;
	logic [VW-1:0]                  out_voice_q;
	logic [NW-1:0]                  out_note_q;
	logic                           out_gate_q;
	logic                           out_last_q;

	logic [KW+3:0]     key_ext;
	logic [NW-1:0]     cur_note;
	logic [VOICES-1:0] match;
	logic [VW-1:0]     free_sel;
	logic [VW-1:0]     rel_sel;
	logic              press_hit;
	logic              emit;
	logic              keep;
	logic              push;
	logic              out_free;
	logic [VW-1:0]     new_voice;
	logic [VW+1:0]     voice_ext;

	assign key_ext  = {4'b0000, key_q};
	assign cur_note = ksva_pkg::key_note(map_lo_q, map_hi_q, key_ext[3:0]);

	// Lowest inactive voice, voice 0 when all are busy; lowest matching voice.
	always_comb begin
		free_sel = '0;
		rel_sel  = '0;
		for (int v = VOICES - 1; v >= 0; v--) begin
			match[v] = act_q[v] && (vnote_q[v] == cur_note);
			if (!act_q[v])
				free_sel = VW'(v);
			if (match[v])
				rel_sel = VW'(v);
		end
	end

	assign press_hit = cmd.press && pressed_q[key_q];
	assign emit      = press_hit || cmd.rel;
	assign keep      = emit && (cnt_q < MAX_CNT);
	assign push      = keep && hold_v_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign new_voice = cmd.rel ? rel_sel : free_sel;

	assign sts.key_last = (key_q == KEY_LAST);
	assign sts.rel_hit  = released_q[key_q] && (|match);
	assign sts.hold_v   = hold_v_q;
	assign sts.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_lo_q    <= '0;
			map_hi_q    <= '0;
			prev_q      <= '0;
			pressed_q   <= '0;
			released_q  <= '0;
			key_q       <= '0;
			act_q       <= '0;
			cnt_q       <= '0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			for (int v = 0; v < VOICES; v++)
				vnote_q[v] <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					ksva_pkg::REG_NOTE_MAP_LOW:  map_lo_q <= cfg_wdata;
					ksva_pkg::REG_NOTE_MAP_HIGH: map_hi_q <= cfg_wdata;
				endcase
			end
			if (cmd.load) begin
				prev_q     <= key_word;
				pressed_q  <= key_word[KEYS-1:0] & ~prev_q[KEYS-1:0];
				released_q <= prev_q[KEYS-1:0] & ~key_word[KEYS-1:0];
				key_q      <= '0;
				cnt_q      <= '0;
			end
			if (cmd.adv_key)
				key_q <= sts.key_last ? '0 : key_q + KW'(1);
			if (press_hit) begin
				act_q[free_sel]   <= 1'b1;
				vnote_q[free_sel] <= cur_note;
			end
			if (cmd.rel)
				act_q[rel_sel] <= 1'b0;
			if (push || cmd.flush) begin
				out_valid_q <= 1'b1;
				out_last_q  <= cmd.flush;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (keep) begin
				cnt_q    <= cnt_q + CNT_W'(1);
				hold_v_q <= 1'b1;
			end else if (cmd.flush) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			hold_voice_q <= new_voice;
			hold_note_q  <= cur_note;
			hold_gate_q  <= !cmd.rel;
		end
		if (push || cmd.flush) begin
			out_voice_q <= hold_voice_q;
			out_note_q  <= hold_note_q;
			out_gate_q  <= hold_gate_q;
		end
	end

	assign voice_ext   = {2'b00, out_voice_q};
	assign out_valid   = out_valid_q;
	assign voice_index = voice_ext[1:0];
	assign note        = out_note_q;
	assign gate        = out_gate_q;
	assign last        = out_last_q;

	`KSVA_ASSERT_ALWAYS(a_out_free, clk, arst_n, (push || cmd.flush) |-> out_free, "held result overwritten")
	`KSVA_ASSERT_ALWAYS(a_cnt_cap, clk, arst_n, cnt_q <= MAX_CNT, "event count past limit")
	`KSVA_ASSERT_NEXT(a_flush_last, clk, arst_n, cmd.flush, out_valid_q && out_last_q, "flush lost last mark")
	`KSVA_ASSERT_ALWAYS(a_load_empty, clk, arst_n, cmd.load |-> !hold_v_q, "stale event at new request")

endmodule

// ===== rtl/core/key_scan_voice_allocator.sv =====
// Key-scan voice allocator: one key-word request in, zero or more voice events out.
// Occupancy per request grows with KEYS and with R, the number of gate-off events: the
// scan takes one key per cycle while the output does not stall, and each release adds a
// step of its own; output stalls add to it. An event is valid the cycle after the next one
// is scanned, the last one after the flush step. One request at a time: the next is taken
// once the last event is in the output register. Reset clears note maps, keys and voices.
module key_scan_voice_allocator #(
	parameter int VOICES = 4,
	parameter int KEYS   = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_wr_en,
	input  logic [ksva_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ksva_pkg::MAP_W-1:0]         cfg_wdata,
	// key-word request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [ksva_pkg::KEY_SPACE-1:0]     key_word,
	// voice event channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [ksva_pkg::VIDX_W-1:0]        voice_index,
	output logic [ksva_pkg::NOTE_W-1:0]        note,
	output logic                               gate,
	output logic                               last
);

	ksva_pkg::dp_cmd_t cmd;
	ksva_pkg::dp_sts_t sts;

	// Sequence the request: load the key diff, scan presses, scan releases,
	// then drain the held event with its last mark.
	ksva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the note maps, key history and voice table; build each event and
	// stage it through a one-deep hold register so the last mark can be set
	// once the scan knows no more events follow.
	ksva_datapath #(
		.VOICES (VOICES),
		.KEYS   (KEYS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.key_word    (key_word),
		.cmd         (cmd),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.voice_index (voice_index),
		.note        (note),
		.gate        (gate),
		.last        (last)
	);

endmodule

// ===== test/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VOICE_COUNT   = 4;
	localparam int KEY_COUNT     = 16;
	// The quiet wait is long enough for a whole request (R up to VOICES gate-offs) to finish,
	// so it covers a request that produced no events at all.
	localparam int SETTLE_CYCLES = 80;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [ksva_pkg::VIDX_W-1:0] voice;
		logic [ksva_pkg::NOTE_W-1:0] note;
		logic                        gate;
		logic                        last;
	} voice_event_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [ksva_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ksva_pkg::MAP_W-1:0]     cfg_wdata;
	logic                           in_valid;
	logic                           in_stall;
	logic [ksva_pkg::KEY_SPACE-1:0] key_word;
	logic                           out_valid;
	logic                           out_stall;
	logic [ksva_pkg::VIDX_W-1:0]    voice_index;
	logic [ksva_pkg::NOTE_W-1:0]    note;
	logic                           gate;
	logic                           last;

	// Shadow of the allocator: note maps, key history and voice table.
	logic [ksva_pkg::MAP_W-1:0]     shadow_map_lo;
	logic [ksva_pkg::MAP_W-1:0]     shadow_map_hi;
	logic [ksva_pkg::KEY_SPACE-1:0] held_keys;
	logic                           voice_busy [VOICE_COUNT];
	logic [ksva_pkg::NOTE_W-1:0]    voice_pitch [VOICE_COUNT];

	voice_event_t expected_voice_events[$];
	int           mismatch_count;
	// While set, neither side inserts gaps or stalls.
	bit           steady_flow;

	key_scan_voice_allocator #(
		.VOICES (VOICE_COUNT),
		.KEYS   (KEY_COUNT)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.key_word    (key_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.voice_index (voice_index),
		.note        (note),
		.gate        (gate),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run (every request stalled at each event).
	initial begin
		#(20ms);
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Note of key k: low seven bits of its byte in the combined map.
	function automatic logic [ksva_pkg::NOTE_W-1:0] key_pitch(input int k);
		logic [ksva_pkg::MAP_W-1:0] bank;
		bank = (k < 8) ? shadow_map_lo : shadow_map_hi;
		return bank[(k % 8) * 8 +: ksva_pkg::NOTE_W];
	endfunction

	function automatic void record_event(input int v,
			input logic [ksva_pkg::NOTE_W-1:0] pitch, input logic on, inout int emitted);
		voice_event_t ev;
		// Drop anything past the event limit; the voice table still moves on.
		if (emitted < ksva_pkg::MAX_RESULTS) begin
			ev.voice = ksva_pkg::VIDX_W'(v);
			ev.note  = pitch;
			ev.gate  = on;
			ev.last  = 1'b0;
			expected_voice_events.push_back(ev);
			emitted++;
		end
	endfunction

	// Work out the gate events of one accepted key word and advance the shadow state.
	function automatic void allocate_voices(input logic [ksva_pkg::KEY_SPACE-1:0] word);
		logic [ksva_pkg::KEY_SPACE-1:0] pressed;
		logic [ksva_pkg::KEY_SPACE-1:0] released;
		logic [ksva_pkg::NOTE_W-1:0]    pitch;
		int                             sel;
		int                             emitted;
		pressed  = word & ~held_keys;
		released = held_keys & ~word;
		emitted  = 0;
		// Presses first: lowest idle voice, or steal voice 0 when all are busy.
		for (int k = 0; k < KEY_COUNT; k++) begin
			if (pressed[k]) begin
				pitch = key_pitch(k);
				sel = 0;
				for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
					if (!voice_busy[v])
						sel = v;
				end
				voice_pitch[sel] = pitch;
				voice_busy[sel]  = 1'b1;
				record_event(sel, pitch, 1'b1, emitted);
			end
		end
		// Releases: every busy voice on the released key's note goes off.
		for (int k = 0; k < KEY_COUNT; k++) begin
			if (released[k]) begin
				pitch = key_pitch(k);
				for (int v = 0; v < VOICE_COUNT; v++) begin
					if (voice_busy[v] && voice_pitch[v] == pitch) begin
						voice_busy[v] = 1'b0;
						record_event(v, pitch, 1'b0, emitted);
					end
				end
			end
		end
		held_keys = word;
		if (emitted > 0)
			expected_voice_events[$].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	function automatic void flag_mismatch(input string msg);
		if (mismatch_count < REPORT_LIMIT)
			$display("%0t: MISMATCH %s", $realtime, msg);
		mismatch_count++;
	endfunction

	// Compare each accepted event with the oldest prediction.
	always @(posedge clk) begin : check_voice_events
		voice_event_t want;
		voice_event_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.voice = voice_index;
			got.note  = note;
			got.gate  = gate;
			got.last  = last;
			if (expected_voice_events.size() == 0) begin
				flag_mismatch($sformatf(
					"unexpected event voice=%0d note=%0d gate=%0b last=%0b",
					got.voice, got.note, got.gate, got.last));
			end else begin
				want = expected_voice_events.pop_front();
				if (got.voice !== want.voice || got.note !== want.note ||
						got.gate !== want.gate || got.last !== want.last)
					flag_mismatch($sformatf({"expected voice=%0d note=%0d gate=%0b last=%0b, ",
						"got voice=%0d note=%0d gate=%0b last=%0b"},
						want.voice, want.note, want.gate, want.last,
						got.voice, got.note, got.gate, got.last));
			end
		end
	end

	// ------------------------------------------------------------------
	// Event sink: random stalls, mostly short, a few long
	// ------------------------------------------------------------------

	initial begin
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (steady_flow) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b1;
				case ($urandom_range(0, 9))
					0: repeat ($urandom_range(20, 50)) @(posedge clk);
					1, 2: repeat ($urandom_range(4, 10)) @(posedge clk);
					default: repeat ($urandom_range(1, 3)) @(posedge clk);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	function automatic int pick_gap();
		int r;
		if (steady_flow)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Hold one request until accepted, predict its events, then idle for a random gap.
	// Valid stays high across a zero gap so the next request follows back to back.
	task automatic send_key_word(input logic [ksva_pkg::KEY_SPACE-1:0] word);
		int gap;
		in_valid <= 1'b1;
		key_word <= word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		allocate_voices(word);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid, drain every predicted event, then let the scan finish.
	task automatic wait_idle();
		if (in_valid)
			in_valid <= 1'b0;
		while (expected_voice_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both note maps on back-to-back cycles while the block is idle.
	task automatic load_note_maps(input logic [ksva_pkg::MAP_W-1:0] lo,
			input logic [ksva_pkg::MAP_W-1:0] hi);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= ksva_pkg::REG_NOTE_MAP_LOW;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_index <= ksva_pkg::REG_NOTE_MAP_HIGH;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_map_lo = lo;
		shadow_map_hi = hi;
	endtask

	// Next scan word: mostly a few keys toggled, sometimes a jump, a hold or all-up.
	function automatic logic [ksva_pkg::KEY_SPACE-1:0] next_key_word(
			input logic [ksva_pkg::KEY_SPACE-1:0] cur);
		logic [ksva_pkg::KEY_SPACE-1:0] nxt;
		int                             r;
		nxt = cur;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			repeat ($urandom_range(1, 3))
				nxt[$urandom_range(0, KEY_COUNT - 1)] ^= 1'b1;
		end else if (r < 70) begin
			nxt = cur;
		end else if (r < 78) begin
			nxt = '0;
		end else if (r < 90) begin
			nxt = ksva_pkg::KEY_SPACE'($urandom);
		end else begin
			nxt = cur | ksva_pkg::KEY_SPACE'($urandom);
		end
		return nxt;
	endfunction

	// Map whose notes come from a small pool so that several voices share a note.
	function automatic logic [ksva_pkg::MAP_W-1:0] clustered_map();
		logic [ksva_pkg::MAP_W-1:0] m;
		for (int b = 0; b < 8; b++)
			m[b * 8 +: 8] = {1'($urandom_range(0, 1)), 7'(40 + 5 * $urandom_range(0, 2))};
		return m;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic apply_reset();
		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= ksva_pkg::REG_NOTE_MAP_LOW;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		key_word  <= '0;
		shadow_map_lo = '0;
		shadow_map_hi = '0;
		held_keys     = '0;
		for (int v = 0; v < VOICE_COUNT; v++) begin
			voice_busy[v]  = 1'b0;
			voice_pitch[v] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// Maps still at reset: every key plays note 0, so one release frees two voices.
	task automatic test_reset_map();
		send_key_word(16'h0001);
		send_key_word(16'h0003);
		send_key_word(16'h0000);
	endtask

	// Lowest and highest key, top note, map bit 7 ignored, and words with no change.
	task automatic test_key_extremes();
		load_note_maps(64'h8F0E_8D0C_0B8A_0908, 64'hFF97_1615_1413_9211);
		send_key_word(16'h8000);
		send_key_word(16'h8001);
		send_key_word(16'h0001);
		send_key_word(16'h0000);
		send_key_word(16'h0000);
		send_key_word(16'h0000);
	endtask

	// All voices busy: further presses take over voice 0.
	task automatic test_voice_steal();
		send_key_word(16'hFFFF);
		send_key_word(16'h0000);
		send_key_word(16'h000F);
		send_key_word(16'h00FF);
		send_key_word(16'h0000);
	endtask

	// Every key on note 127: releases hit several voices; press and release in one word.
	task automatic test_shared_note();
		load_note_maps('1, '1);
		send_key_word(16'h000F);
		send_key_word(16'h0000);
		send_key_word(16'hFFFF);
		send_key_word(16'h7FFF);
		send_key_word(16'h0000);
		send_key_word(16'h00F0);
		send_key_word(16'h0F00);
		send_key_word(16'h0000);
	endtask

	// Keyboard-like scan traffic under one map setting, with steady stretches.
	task automatic test_random_scan(input int items, input logic [ksva_pkg::MAP_W-1:0] lo,
			input logic [ksva_pkg::MAP_W-1:0] hi);
		logic [ksva_pkg::KEY_SPACE-1:0] word;
		load_note_maps(lo, hi);
		word = held_keys;
		for (int i = 0; i < items; i++) begin
			if (i % 20 == 0)
				steady_flow = ($urandom_range(0, 3) == 0);
			word = next_key_word(word);
			send_key_word(word);
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		mismatch_count = 0;
		steady_flow    = 1'b0;
		apply_reset();

		test_reset_map();
		test_key_extremes();
		test_voice_steal();
		test_shared_note();

		test_random_scan(80, {$urandom, $urandom}, {$urandom, $urandom});
		test_random_scan(80, clustered_map(), clustered_map());
		test_random_scan(40, 64'h4C4A_4845_4341_3F3C, 64'h5855_5351_4F4D_4C4A);
		test_random_scan(30, '1, '0);

		wait_idle();
		if (mismatch_count == 0 && expected_voice_events.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
